FILE: rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// Word types, operation codes and flag positions for the instruction execute
// block.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam int PC_W   = 13;
    localparam int KIND_W = 6;
    localparam int INS_W  = 14;

    localparam logic [KIND_W-1:0] K_ADDWF  = 6'd0;
    localparam logic [KIND_W-1:0] K_ANDWF  = 6'd1;
    localparam logic [KIND_W-1:0] K_CLRF   = 6'd2;
    localparam logic [KIND_W-1:0] K_CLRW   = 6'd3;
    localparam logic [KIND_W-1:0] K_COMF   = 6'd4;
    localparam logic [KIND_W-1:0] K_DECF   = 6'd5;
    localparam logic [KIND_W-1:0] K_DECFSZ = 6'd6;
    localparam logic [KIND_W-1:0] K_INCF   = 6'd7;
    localparam logic [KIND_W-1:0] K_INCFSZ = 6'd8;
    localparam logic [KIND_W-1:0] K_IORWF  = 6'd9;
    localparam logic [KIND_W-1:0] K_MOVF   = 6'd10;
    localparam logic [KIND_W-1:0] K_MOVWF  = 6'd11;
    localparam logic [KIND_W-1:0] K_NOP    = 6'd12;
    localparam logic [KIND_W-1:0] K_RLF    = 6'd13;
    localparam logic [KIND_W-1:0] K_RRF    = 6'd14;
    localparam logic [KIND_W-1:0] K_SUBWF  = 6'd15;
    localparam logic [KIND_W-1:0] K_SWAPF  = 6'd16;
    localparam logic [KIND_W-1:0] K_XORWF  = 6'd17;
    localparam logic [KIND_W-1:0] K_BCF    = 6'd18;
    localparam logic [KIND_W-1:0] K_BSF    = 6'd19;
    localparam logic [KIND_W-1:0] K_BTFSC  = 6'd20;
    localparam logic [KIND_W-1:0] K_BTFSS  = 6'd21;
    localparam logic [KIND_W-1:0] K_ADDLW  = 6'd22;
    localparam logic [KIND_W-1:0] K_ANDLW  = 6'd23;
    localparam logic [KIND_W-1:0] K_CALL   = 6'd24;
    localparam logic [KIND_W-1:0] K_CLRWDT = 6'd25;
    localparam logic [KIND_W-1:0] K_GOTO   = 6'd26;
    localparam logic [KIND_W-1:0] K_IORLW  = 6'd27;
    localparam logic [KIND_W-1:0] K_MOVLW  = 6'd28;
    localparam logic [KIND_W-1:0] K_RETFIE = 6'd29;
    localparam logic [KIND_W-1:0] K_RETLW  = 6'd30;
    localparam logic [KIND_W-1:0] K_RETURN = 6'd31;
    localparam logic [KIND_W-1:0] K_SLEEP  = 6'd32;
    localparam logic [KIND_W-1:0] K_SUBLW  = 6'd33;
    localparam logic [KIND_W-1:0] K_XORLW  = 6'd34;

    localparam logic [2:0] FLAG_NONE = 3'b000;
    localparam logic [2:0] FLAG_C    = 3'b001;
    localparam logic [2:0] FLAG_Z    = 3'b100;
    localparam logic [2:0] FLAG_ALL  = 3'b111;

    localparam logic [1:0] CYC_ONE = 2'd1;
    localparam logic [1:0] CYC_TWO = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [INS_W-1:0]  instruction;
        logic [7:0]        file_value;
        logic              carry_in;
        logic [7:0]        pclath_value;
    } in_word_t;

    typedef struct packed {
        logic            file_write_enable;
        logic [6:0]      file_address;
        logic [7:0]      file_write_value;
        logic [7:0]      w_value;
        logic [PC_W-1:0] next_pc;
        logic            carry_out;
        logic            digit_carry_out;
        logic            zero_out;
        logic [2:0]      flag_mask;
        logic [1:0]      cycle_count;
        logic            set_gie;
    } out_word_t;

endpackage

FILE: rtl/mcu_instruction_execute.sv
// ----------------------------------------------------------------------------
// mcu_instruction_execute
// Executes one decoded mid-range instruction per word. Holds W, the program
// counter and a circular return stack of STACK_DEPTH entries. A word passes
// an input register, one pass of byte logic and a result register. One word
// per cycle is sustained while the receiver takes result words. W, PC and
// the stack are updated as the result register loads, so the next word
// sees them. The input register takes one more word while a finished word
// waits downstream, so up to one word sits in each register before the
// input stalls.
// ----------------------------------------------------------------------------
module mcu_instruction_execute
    import mie_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    logic                in_valid_reg;
    in_word_t            in_data_reg;
    logic                m_valid_reg;
    out_word_t           m_data_reg;
    logic [7:0]          w_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [PC_W-1:0]     stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]     sp_reg;

    logic                advance;
    logic [SP_W-1:0]     sp_inc;
    logic [SP_W-1:0]     sp_dec;
    logic [PC_W-1:0]     pc_inc;
    logic [PC_W-1:0]     pc_inc2;
    logic [PC_W-1:0]     target;
    logic [PC_W-1:0]     pop_data;
    logic [7:0]          f;
    logic [7:0]          lit;
    logic [2:0]          bitn;
    logic [7:0]          bit_sel;
    logic [8:0]          add_f;
    logic [8:0]          add_l;
    logic [4:0]          add_f_lo;
    logic [4:0]          add_l_lo;

    logic [7:0]          res;
    logic                has_res;
    logic                force_file;
    logic                c_flag;
    logic                dc_flag;
    logic [2:0]          mask;
    logic [7:0]          w_next;
    logic [PC_W-1:0]     pc_next;
    logic [1:0]          cycles;
    logic                gie;
    logic                skip;
    logic                push;
    logic                pop;
    logic                fwe;
    logic [7:0]          fval;
    out_word_t           m_data_next;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sp_inc   = (sp_reg == SP_LAST) ? '0 : sp_reg + 1'b1;
    assign sp_dec   = (sp_reg == '0) ? SP_LAST : sp_reg - 1'b1;
    assign pop_data = stack_reg[sp_dec];

    assign f        = in_data_reg.file_value;
    assign lit      = in_data_reg.instruction[7:0];
    assign bitn     = in_data_reg.instruction[9:7];
    assign bit_sel  = 8'b1 << bitn;
    assign pc_inc   = pc_reg + 1'b1;
    assign pc_inc2  = pc_reg + 2'd2;
    assign target   = {in_data_reg.pclath_value[4:3], in_data_reg.instruction[10:0]};
    assign add_f    = {1'b0, f} + {1'b0, w_reg};
    assign add_l    = {1'b0, lit} + {1'b0, w_reg};
    assign add_f_lo = {1'b0, f[3:0]} + {1'b0, w_reg[3:0]};
    assign add_l_lo = {1'b0, lit[3:0]} + {1'b0, w_reg[3:0]};

    always_comb begin
        res        = 8'h00;
        has_res    = 1'b0;
        force_file = 1'b0;
        c_flag     = 1'b0;
        dc_flag    = 1'b0;
        mask       = FLAG_NONE;
        w_next     = w_reg;
        pc_next    = pc_inc;
        cycles     = CYC_ONE;
        gie        = 1'b0;
        skip       = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;

        unique case (in_data_reg.kind)
            K_ADDWF: begin
                res = add_f[7:0]; c_flag = add_f[8]; dc_flag = add_f_lo[4];
                mask = FLAG_ALL; has_res = 1'b1;
            end
            K_ANDWF: begin res = f & w_reg; mask = FLAG_Z; has_res = 1'b1; end
            K_CLRF:  begin res = 8'h00; mask = FLAG_Z; force_file = 1'b1; end
            K_CLRW:  begin w_next = 8'h00; res = 8'h00; mask = FLAG_Z; end
            K_COMF:  begin res = ~f; mask = FLAG_Z; has_res = 1'b1; end
            K_DECF:  begin res = f - 1'b1; mask = FLAG_Z; has_res = 1'b1; end
            K_DECFSZ: begin
                res = f - 1'b1; has_res = 1'b1; skip = (f == 8'h01);
            end
            K_INCF:  begin res = f + 1'b1; mask = FLAG_Z; has_res = 1'b1; end
            K_INCFSZ: begin
                res = f + 1'b1; has_res = 1'b1; skip = (f == 8'hff);
            end
            K_IORWF: begin res = f | w_reg; mask = FLAG_Z; has_res = 1'b1; end
            K_MOVF:  begin res = f; mask = FLAG_Z; has_res = 1'b1; end
            K_MOVWF: begin res = w_reg; force_file = 1'b1; end
            K_RLF: begin
                res = {f[6:0], in_data_reg.carry_in}; c_flag = f[7];
                mask = FLAG_C; has_res = 1'b1;
            end
            K_RRF: begin
                res = {in_data_reg.carry_in, f[7:1]}; c_flag = f[0];
                mask = FLAG_C; has_res = 1'b1;
            end
            K_SUBWF: begin
                res = f - w_reg; c_flag = (f >= w_reg);
                dc_flag = (f[3:0] >= w_reg[3:0]); mask = FLAG_ALL; has_res = 1'b1;
            end
            K_SWAPF: begin res = {f[3:0], f[7:4]}; has_res = 1'b1; end
            K_XORWF: begin res = f ^ w_reg; mask = FLAG_Z; has_res = 1'b1; end
            K_BCF:   begin res = f & ~bit_sel; force_file = 1'b1; end
            K_BSF:   begin res = f | bit_sel; force_file = 1'b1; end
            K_BTFSC: skip = ((f & bit_sel) == 8'h00);
            K_BTFSS: skip = ((f & bit_sel) != 8'h00);
            K_ADDLW: begin
                res = add_l[7:0]; c_flag = add_l[8]; dc_flag = add_l_lo[4];
                mask = FLAG_ALL; w_next = add_l[7:0];
            end
            K_ANDLW: begin res = lit & w_reg; mask = FLAG_Z; w_next = lit & w_reg; end
            K_CALL:  begin push = 1'b1; pc_next = target; cycles = CYC_TWO; end
            K_GOTO:  begin pc_next = target; cycles = CYC_TWO; end
            K_IORLW: begin res = lit | w_reg; mask = FLAG_Z; w_next = lit | w_reg; end
            K_MOVLW: w_next = lit;
            K_RETFIE: begin pop = 1'b1; pc_next = pop_data; cycles = CYC_TWO; gie = 1'b1; end
            K_RETLW: begin
                w_next = lit; pop = 1'b1; pc_next = pop_data; cycles = CYC_TWO;
            end
            K_RETURN: begin pop = 1'b1; pc_next = pop_data; cycles = CYC_TWO; end
            K_SUBLW: begin
                res = lit - w_reg; c_flag = (lit >= w_reg);
                dc_flag = (lit[3:0] >= w_reg[3:0]); mask = FLAG_ALL;
                w_next = lit - w_reg;
            end
            K_XORLW: begin res = lit ^ w_reg; mask = FLAG_Z; w_next = lit ^ w_reg; end
            default: begin end
        endcase

        fwe  = force_file || (has_res && in_data_reg.instruction[7]);
        fval = fwe ? res : 8'h00;
        if (has_res && !fwe) begin
            w_next = res;
        end
        if (skip) begin
            pc_next = pc_inc2;
            cycles  = CYC_TWO;
        end

        m_data_next.file_write_enable = fwe;
        m_data_next.file_address      = in_data_reg.instruction[6:0];
        m_data_next.file_write_value  = fval;
        m_data_next.w_value           = w_next;
        m_data_next.next_pc           = pc_next;
        m_data_next.carry_out         = mask[0] & c_flag;
        m_data_next.digit_carry_out   = mask[1] & dc_flag;
        m_data_next.zero_out          = mask[2] & (res == 8'h00);
        m_data_next.flag_mask         = mask;
        m_data_next.cycle_count       = cycles;
        m_data_next.set_gie           = gie;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg  <= 8'h00;
            pc_reg <= '0;
            sp_reg <= '0;
            for (int i = 0; i < STACK_DEPTH; i++) begin
                stack_reg[i] <= '0;
            end
        end else if (advance) begin
            w_reg  <= w_next;
            pc_reg <= pc_next;
            if (push) begin
                stack_reg[sp_reg] <= pc_inc;
                sp_reg            <= sp_inc;
            end else if (pop) begin
                sp_reg <= sp_dec;
            end
        end
    end

endmodule

FILE: rtl/mie_checker.sv
// ----------------------------------------------------------------------------
// mie_checker
// Port-level checks on both channels of the instruction execute block.
// ----------------------------------------------------------------------------
module mie_checker
    import mie_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

    a_cycles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cycle_count == CYC_ONE || m_data.cycle_count == CYC_TWO)
        else $error("cycle count out of range");

    a_gie: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.set_gie |->
            m_data.cycle_count == CYC_TWO && m_data.flag_mask == FLAG_NONE &&
            !m_data.file_write_enable)
        else $error("interrupt return with side effects");

    a_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.carry_out <= m_data.flag_mask[0]) &&
            (m_data.digit_carry_out <= m_data.flag_mask[1]) &&
            (m_data.zero_out <= m_data.flag_mask[2]) &&
            (m_data.file_write_enable || m_data.file_write_value == 8'h00))
        else $error("masked flag or idle write value not cleared");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("accepted word produced no result word");

endmodule

bind mcu_instruction_execute mie_checker u_mie_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: sim/mcu_exec_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcu_exec_checker
// Watches both channels of the instruction execute block. Every accepted
// instruction word is run through a local model of W, the program counter and
// the circular return stack; every result word is compared field by field
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mcu_exec_checker
    import mie_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        fail_count,
    output int        pending_count
);

    logic [7:0]      w_now;
    logic [PC_W-1:0] pc_now;
    logic [PC_W-1:0] ret_stack [STACK_DEPTH];
    int              ret_sp;
    out_word_t       pending_results [$];
    out_word_t       want_word;
    int              mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [PC_W-1:0] pop_return();
        ret_sp = (ret_sp + STACK_DEPTH - 1) % STACK_DEPTH;
        return ret_stack[ret_sp];
    endfunction

    function automatic out_word_t execute_instruction(in_word_t iw);
        logic [7:0]      lit;
        logic [7:0]      f;
        logic [7:0]      w;
        logic [2:0]      bitn;
        logic [PC_W-1:0] target;
        logic [PC_W-1:0] nxt;
        logic [8:0]      res;
        logic [4:0]      nib;
        logic            has_res;
        logic            force_file;
        logic            skip;
        logic            c;
        logic            dc;
        logic [2:0]      mask;
        logic [1:0]      cyc;
        logic            gie;
        out_word_t       o;

        lit        = iw.instruction[7:0];
        f          = iw.file_value;
        w          = w_now;
        bitn       = iw.instruction[9:7];
        target     = {iw.pclath_value[4:3], iw.instruction[10:0]};
        res        = '0;
        nib        = '0;
        has_res    = 1'b0;
        force_file = 1'b0;
        skip       = 1'b0;
        c          = 1'b0;
        dc         = 1'b0;
        mask       = FLAG_NONE;
        nxt        = pc_now + 1'b1;
        cyc        = CYC_ONE;
        gie        = 1'b0;
        o          = '0;

        case (iw.kind)
            K_ADDWF: begin
                res     = {1'b0, f} + {1'b0, w};
                nib     = {1'b0, f[3:0]} + {1'b0, w[3:0]};
                c       = res[8];
                dc      = nib[4];
                mask    = FLAG_ALL;
                has_res = 1'b1;
            end
            K_ANDWF: begin
                res     = {1'b0, f & w};
                mask    = FLAG_Z;
                has_res = 1'b1;
            end
            K_CLRF: begin
                mask       = FLAG_Z;
                force_file = 1'b1;
            end
            K_CLRW: begin
                w    = '0;
                mask = FLAG_Z;
            end
            K_COMF: begin
                res     = {1'b0, ~f};
                mask    = FLAG_Z;
                has_res = 1'b1;
            end
            K_DECF: begin
                res     = {1'b0, f - 8'd1};
                mask    = FLAG_Z;
                has_res = 1'b1;
            end
            K_DECFSZ: begin
                res     = {1'b0, f - 8'd1};
                has_res = 1'b1;
                skip    = (res[7:0] == 8'd0);
            end
            K_INCF: begin
                res     = {1'b0, f + 8'd1};
                mask    = FLAG_Z;
                has_res = 1'b1;
            end
            K_INCFSZ: begin
                res     = {1'b0, f + 8'd1};
                has_res = 1'b1;
                skip    = (res[7:0] == 8'd0);
            end
            K_IORWF: begin
                res     = {1'b0, f | w};
                mask    = FLAG_Z;
                has_res = 1'b1;
            end
            K_MOVF: begin
                res     = {1'b0, f};
                mask    = FLAG_Z;
                has_res = 1'b1;
            end
            K_MOVWF: begin
                res        = {1'b0, w};
                force_file = 1'b1;
            end
            K_RLF: begin
                res     = {1'b0, f[6:0], iw.carry_in};
                c       = f[7];
                mask    = FLAG_C;
                has_res = 1'b1;
            end
            K_RRF: begin
                res     = {1'b0, iw.carry_in, f[7:1]};
                c       = f[0];
                mask    = FLAG_C;
                has_res = 1'b1;
            end
            K_SUBWF: begin
                res     = {1'b0, f - w};
                c       = (f >= w);
                dc      = (f[3:0] >= w[3:0]);
                mask    = FLAG_ALL;
                has_res = 1'b1;
            end
            K_SWAPF: begin
                res     = {1'b0, f[3:0], f[7:4]};
                has_res = 1'b1;
            end
            K_XORWF: begin
                res     = {1'b0, f ^ w};
                mask    = FLAG_Z;
                has_res = 1'b1;
            end
            K_BCF: begin
                res        = {1'b0, f & ~(8'd1 << bitn)};
                force_file = 1'b1;
            end
            K_BSF: begin
                res        = {1'b0, f | (8'd1 << bitn)};
                force_file = 1'b1;
            end
            K_BTFSC: skip = !f[bitn];
            K_BTFSS: skip = f[bitn];
            K_ADDLW: begin
                res  = {1'b0, lit} + {1'b0, w};
                nib  = {1'b0, lit[3:0]} + {1'b0, w[3:0]};
                c    = res[8];
                dc   = nib[4];
                mask = FLAG_ALL;
                w    = res[7:0];
            end
            K_ANDLW: begin
                res  = {1'b0, lit & w};
                mask = FLAG_Z;
                w    = res[7:0];
            end
            K_CALL: begin
                ret_stack[ret_sp] = pc_now + 1'b1;
                ret_sp            = (ret_sp + 1) % STACK_DEPTH;
                nxt               = target;
                cyc               = CYC_TWO;
            end
            K_GOTO: begin
                nxt = target;
                cyc = CYC_TWO;
            end
            K_IORLW: begin
                res  = {1'b0, lit | w};
                mask = FLAG_Z;
                w    = res[7:0];
            end
            K_MOVLW: w = lit;
            K_RETFIE: begin
                nxt = pop_return();
                cyc = CYC_TWO;
                gie = 1'b1;
            end
            K_RETLW: begin
                w   = lit;
                nxt = pop_return();
                cyc = CYC_TWO;
            end
            K_RETURN: begin
                nxt = pop_return();
                cyc = CYC_TWO;
            end
            K_SUBLW: begin
                res  = {1'b0, lit - w};
                c    = (lit >= w);
                dc   = (lit[3:0] >= w[3:0]);
                mask = FLAG_ALL;
                w    = res[7:0];
            end
            K_XORLW: begin
                res  = {1'b0, lit ^ w};
                mask = FLAG_Z;
                w    = res[7:0];
            end
            default: ;
        endcase

        if (force_file || (has_res && iw.instruction[7])) begin
            o.file_write_enable = 1'b1;
            o.file_write_value  = res[7:0];
        end else if (has_res) begin
            w = res[7:0];
        end
        if (skip) begin
            nxt = pc_now + 2'd2;
            cyc = CYC_TWO;
        end

        w_now  = w;
        pc_now = nxt;

        o.file_address    = iw.instruction[6:0];
        o.w_value         = w;
        o.next_pc         = nxt;
        o.carry_out       = mask[0] ? c : 1'b0;
        o.digit_carry_out = mask[1] ? dc : 1'b0;
        o.zero_out        = mask[2] ? (res[7:0] == 8'd0) : 1'b0;
        o.flag_mask       = mask;
        o.cycle_count     = cyc;
        o.set_gie         = gie;
        return o;
    endfunction

    task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            w_now  = '0;
            pc_now = '0;
            ret_sp = 0;
            foreach (ret_stack[i]) ret_stack[i] = '0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result word expected none, actual 0x%0h", $time, m_data);
                    mismatches++;
                end else begin
                    want_word = pending_results.pop_front();
                    check_field("file_write_enable", 16'(want_word.file_write_enable),
                                16'(m_data.file_write_enable));
                    check_field("file_address", 16'(want_word.file_address),
                                16'(m_data.file_address));
                    check_field("file_write_value", 16'(want_word.file_write_value),
                                16'(m_data.file_write_value));
                    check_field("w_value", 16'(want_word.w_value), 16'(m_data.w_value));
                    check_field("next_pc", 16'(want_word.next_pc), 16'(m_data.next_pc));
                    check_field("carry_out", 16'(want_word.carry_out),
                                16'(m_data.carry_out));
                    check_field("digit_carry_out", 16'(want_word.digit_carry_out),
                                16'(m_data.digit_carry_out));
                    check_field("zero_out", 16'(want_word.zero_out), 16'(m_data.zero_out));
                    check_field("flag_mask", 16'(want_word.flag_mask),
                                16'(m_data.flag_mask));
                    check_field("cycle_count", 16'(want_word.cycle_count),
                                16'(m_data.cycle_count));
                    check_field("set_gie", 16'(want_word.set_gie), 16'(m_data.set_gie));
                end
            end
            if (s_valid && s_ready) pending_results.push_back(execute_instruction(s_data));
        end
        pending_count <= pending_results.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the instruction execute block with a directed run of every operation
// and its corner cases, then random instruction words with call and return
// chains, under bursty input and a stalling receiver. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import mie_pkg::*;

    localparam int STACK_DEPTH = 8;
    localparam int N_RANDOM    = 1900;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_AT     = 900;
    localparam int HOLD_CYCLES = 80;
    localparam int CHAIN_LEN   = 20;

    localparam logic [KIND_W-1:0] K_FIRST_UNUSED = 6'd35;
    localparam logic [KIND_W-1:0] K_LAST_UNUSED  = 6'd63;

    localparam int RX_FREE     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    int        fail_count;
    int        pending_count;

    in_word_t    directed_words [$];
    in_word_t    next_word;
    int          items_sent  = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          chain_left  = 0;
    bit          all_sent    = 1'b0;
    int          idle_cycles = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    int          rx_mode     = RX_FREE;
    int          rx_cyc      = 0;
    logic [7:0]  corner_bytes [6] = '{8'h00, 8'h01, 8'hFF, 8'h0F, 8'h10, 8'h80};
    logic [KIND_W-1:0] return_kinds [3] = '{K_RETURN, K_RETLW, K_RETFIE};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mcu_instruction_execute #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mcu_exec_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic in_word_t op(logic [KIND_W-1:0] kind, logic [INS_W-1:0] ins,
                                    logic [7:0] fv = 8'h00, logic cin = 1'b0,
                                    logic [7:0] pl = 8'h00);
        in_word_t iw;
        iw.kind         = kind;
        iw.instruction  = ins;
        iw.file_value   = fv;
        iw.carry_in     = cin;
        iw.pclath_value = pl;
        return iw;
    endfunction

    initial begin
        directed_words.push_back(op(K_MOVLW,  14'h00FF));
        directed_words.push_back(op(K_ADDWF,  14'h0000, 8'h01));
        directed_words.push_back(op(K_ADDLW,  14'h00FF));
        directed_words.push_back(op(K_SUBWF,  14'h00A5, 8'h00));
        directed_words.push_back(op(K_SUBLW,  14'h00FF));
        directed_words.push_back(op(K_XORLW,  14'h00FF));
        directed_words.push_back(op(K_ANDLW,  14'h00F0));
        directed_words.push_back(op(K_IORLW,  14'h000F));
        directed_words.push_back(op(K_MOVWF,  14'h007F));
        directed_words.push_back(op(K_CLRF,   14'h3FFF, 8'hFF, 1'b1, 8'hFF));
        directed_words.push_back(op(K_CLRW,   14'h0000));
        directed_words.push_back(op(K_COMF,   14'h0080, 8'hFF));
        directed_words.push_back(op(K_DECF,   14'h0080, 8'h00));
        directed_words.push_back(op(K_DECFSZ, 14'h0000, 8'h01));
        directed_words.push_back(op(K_INCF,   14'h0080, 8'hFF));
        directed_words.push_back(op(K_INCFSZ, 14'h0080, 8'hFF));
        directed_words.push_back(op(K_IORWF,  14'h0000, 8'h00));
        directed_words.push_back(op(K_ANDWF,  14'h0080, 8'hFF));
        directed_words.push_back(op(K_XORWF,  14'h0000, 8'h5A));
        directed_words.push_back(op(K_MOVF,   14'h0080, 8'h00));
        directed_words.push_back(op(K_RLF,    14'h0000, 8'h80, 1'b1));
        directed_words.push_back(op(K_RRF,    14'h0080, 8'h01, 1'b1));
        directed_words.push_back(op(K_SWAPF,  14'h0080, 8'hA5));
        directed_words.push_back(op(K_BCF,    14'h0380, 8'hFF));
        directed_words.push_back(op(K_BSF,    14'h0000, 8'h00));
        directed_words.push_back(op(K_BTFSC,  14'h0380, 8'h7F));
        directed_words.push_back(op(K_BTFSS,  14'h0000, 8'h01));
        directed_words.push_back(op(K_BTFSC,  14'h0380, 8'h80));
        directed_words.push_back(op(K_GOTO,   14'h07FF, 8'h00, 1'b0, 8'h18));
        directed_words.push_back(op(K_NOP,    14'h0000));
        directed_words.push_back(op(K_GOTO,   14'h07FF, 8'h00, 1'b0, 8'hFF));
        directed_words.push_back(op(K_DECFSZ, 14'h0000, 8'h01));
        directed_words.push_back(op(K_CALL,   14'h0000, 8'h00, 1'b0, 8'hE7));
        directed_words.push_back(op(K_RETURN, 14'h0000));
        directed_words.push_back(op(K_RETURN, 14'h0000));
        directed_words.push_back(op(K_RETLW,  14'h00AA));
        directed_words.push_back(op(K_RETFIE, 14'h0000));
        directed_words.push_back(op(K_CLRWDT, 14'h0000));
        directed_words.push_back(op(K_SLEEP,  14'h0000));
        directed_words.push_back(op(K_FIRST_UNUSED, 14'h0000));
        directed_words.push_back(op(K_LAST_UNUSED,  14'h3FFF, 8'hFF, 1'b1, 8'hFF));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (!all_sent);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // sender: bursts of words, random gaps, call/return chains in the random part
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (items_sent == directed_words.size() + N_RANDOM) begin
                s_valid  <= 1'b0;
                all_sent <= 1'b1;
            end else if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left--;
            end else begin
                if (items_sent < directed_words.size()) begin
                    next_word = directed_words[items_sent];
                end else begin
                    if (chain_left > 0) begin
                        next_word.kind = (chain_left > CHAIN_LEN / 2) ? K_CALL
                                       : return_kinds[$urandom_range(0, 2)];
                        chain_left--;
                    end else if ($urandom_range(0, 39) == 0) begin
                        next_word.kind = K_CALL;
                        chain_left     = CHAIN_LEN - 1;
                    end else if ($urandom_range(0, 15) == 0) begin
                        next_word.kind = KIND_W'($urandom_range(K_FIRST_UNUSED,
                                                                K_LAST_UNUSED));
                    end else begin
                        next_word.kind = KIND_W'($urandom_range(K_ADDWF, K_XORLW));
                    end
                    next_word.instruction  = INS_W'($urandom_range(0, 16383));
                    next_word.file_value   = ($urandom_range(0, 3) == 0)
                                           ? corner_bytes[$urandom_range(0, 5)]
                                           : 8'($urandom_range(0, 255));
                    next_word.carry_in     = 1'($urandom_range(0, 1));
                    next_word.pclath_value = 8'($urandom_range(0, 255));
                end
                s_data     <= next_word;
                s_valid    <= 1'b1;
                items_sent <= items_sent + 1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: stall mode re-picked at random, one long hold mid-run
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cyc++;
            if (rx_cyc % 50 == 0) rx_mode = $urandom_range(RX_FREE, RX_PERIODIC);
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (rx_cyc % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

endmodule
